### design/vector_variance_probe_select_macros.svh
// assertion helpers for the variance probe selector
`ifndef VECTOR_VARIANCE_PROBE_SELECT_MACROS_SVH
`define VECTOR_VARIANCE_PROBE_SELECT_MACROS_SVH
`ifndef SYNTHESIS
`define VVPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vvps check failed");
`define VVPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vvps check failed");
`else
`define VVPS_ASSERT(lbl, prop)
`define VVPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### design/vvps_pkg.sv
package vvps_pkg;

  localparam int ELEM_W    = 16;
  localparam int SUM_W     = 33;
  localparam int SQ_W      = 47;
  localparam int CNT_W     = 17;
  localparam int VAR_W     = 31;
  localparam int PROBE_W   = 10;
  localparam int ZCL_W     = 17;
  localparam int MUL_W     = 32;
  localparam int PROD_W    = 64;
  localparam int DEN_W     = 33;
  localparam int QUOT_W    = 32;
  localparam int DIV_STEPS = 32;
  localparam int STEP_W    = 5;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [VAR_W-1:0]   HIGH_THR_RST = 31'd8388608;
  localparam logic [VAR_W-1:0]   LOW_THR_RST  = 31'd1677722;
  localparam logic [PROBE_W-1:0] PROBE_H_RST  = 10'd16;
  localparam logic [PROBE_W-1:0] PROBE_L_RST  = 10'd2;
  localparam logic [PROBE_W-1:0] PROBE_M_RST  = 10'd8;
  localparam logic [ZCL_W-1:0]   ZCL_RST      = 17'd1024;

  typedef enum logic [2:0] {
    REG_HIGH_THR = 3'd0,
    REG_LOW_THR  = 3'd1,
    REG_PROBE_H  = 3'd2,
    REG_PROBE_L  = 3'd3,
    REG_PROBE_M  = 3'd4,
    REG_ZCL      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [VAR_W-1:0]   high_thr;
    logic [VAR_W-1:0]   low_thr;
    logic [PROBE_W-1:0] probe_high;
    logic [PROBE_W-1:0] probe_low;
    logic [PROBE_W-1:0] probe_mid;
    logic [ZCL_W-1:0]   zc_len;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### design/vvps_mul.sv
module vvps_mul (
  input  logic                        clk,
  input  logic [vvps_pkg::MUL_W-1:0]  a,
  input  logic [vvps_pkg::MUL_W-1:0]  b,
  output logic [vvps_pkg::PROD_W-1:0] p_r
);
  import vvps_pkg::*;

  always_ff @(posedge clk) begin
    p_r <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

### design/vvps_div.sv
module vvps_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [vvps_pkg::PROD_W-1:0]  num,
  input  logic [vvps_pkg::DEN_W-1:0]   den,
  output vvps_pkg::div_stat_t          stat,
  output logic [vvps_pkg::VAR_W-1:0]   quot
);
  import vvps_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   step_r;
  logic [PROD_W-1:0]   rem_r;
  logic [PROD_W-1:0]   dsh_r;
  logic [QUOT_W-1:0]   q_r;
  logic                ge;

  assign ge = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle from the top
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= {den, {(QUOT_W-1){1'b0}}};
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[QUOT_W-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  // top quotient bit set means the result does not fit
  assign quot = q_r[QUOT_W-1] ? {VAR_W{1'b1}} : q_r[VAR_W-1:0];

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### design/vvps_cfg.sv
module vvps_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vvps_pkg::ADDR_W-1:0]  paddr,
  input  logic [vvps_pkg::DATA_W-1:0]  pwdata,
  output logic [vvps_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output vvps_pkg::cfg_t               cfg
);
  import vvps_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_thr   <= HIGH_THR_RST;
      cfg_r.low_thr    <= LOW_THR_RST;
      cfg_r.probe_high <= PROBE_H_RST;
      cfg_r.probe_low  <= PROBE_L_RST;
      cfg_r.probe_mid  <= PROBE_M_RST;
      cfg_r.zc_len     <= ZCL_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_HIGH_THR: cfg_r.high_thr   <= pwdata[VAR_W-1:0];
        REG_LOW_THR:  cfg_r.low_thr    <= pwdata[VAR_W-1:0];
        REG_PROBE_H:  cfg_r.probe_high <= pwdata[PROBE_W-1:0];
        REG_PROBE_L:  cfg_r.probe_low  <= pwdata[PROBE_W-1:0];
        REG_PROBE_M:  cfg_r.probe_mid  <= pwdata[PROBE_W-1:0];
        REG_ZCL:      cfg_r.zc_len     <= pwdata[ZCL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HIGH_THR: prdata = DATA_W'(cfg_r.high_thr);
      REG_LOW_THR:  prdata = DATA_W'(cfg_r.low_thr);
      REG_PROBE_H:  prdata = DATA_W'(cfg_r.probe_high);
      REG_PROBE_L:  prdata = DATA_W'(cfg_r.probe_low);
      REG_PROBE_M:  prdata = DATA_W'(cfg_r.probe_mid);
      REG_ZCL:      prdata = DATA_W'(cfg_r.zc_len);
      default:      prdata = '0;
    endcase
  end

endmodule

### design/vector_variance_probe_select.sv
// an element without last passes the square and add states; past MAX_LEN it is dropped
// a last element then goes to T0 to T4 and the final state, also when past MAX_LEN
// elements are taken only in idle; the square and T0 to T3 share the 32x32 multiplier
// the per vector tail is set by the 32 step divider that forms the variance
// reset: synchronous active low, clears the accumulators and restores registers
`include "vector_variance_probe_select_macros.svh"
module vector_variance_probe_select #(
  parameter int MAX_LEN = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // element
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // probe_count, variance, zero pad
  output logic [1:0]  out_tuser,   // bypass, too_long
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import vvps_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_SQ   = 9'b000000010,
    ST_ADD  = 9'b000000100,
    ST_T0   = 9'b000001000,
    ST_T1   = 9'b000010000,
    ST_T2   = 9'b000100000,
    ST_T3   = 9'b001000000,
    ST_T4   = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  cfg_t      cfg;
  div_stat_t div_stat;

  state_t              state_r, state_nxt;
  logic [ELEM_W-1:0]   e_r;
  logic                last_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SQ_W-1:0]     sq_r, sq_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                ovf_r, ovf_nxt;
  logic [PROD_W-1:0]   acc_r;
  logic [MUL_W-1:0]    mag_r;
  logic                out_valid_r;
  logic [PROBE_W-1:0]  probe_out_r;
  logic [VAR_W-1:0]    var_out_r;
  logic                zc_out_r;
  logic                tl_out_r;

  logic                in_acc;
  logic                room;
  logic                fin_load;
  logic [ELEM_W:0]     e_ext;
  logic [ELEM_W:0]     e_mag;
  logic [SUM_W-1:0]    sum_mag;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic                div_start;
  logic [VAR_W-1:0]    quot;
  logic [PROBE_W-1:0]  probe_sel;
  logic                zc_sel;

  vvps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  vvps_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  vvps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r),
    .den   (mul_p[DEN_W-1:0]),
    .stat  (div_stat),
    .quot  (quot)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign room      = cnt_r < CNT_W'(MAX_LEN);
  assign fin_load  = (state_r == ST_FIN) && !div_stat.busy && (!out_valid_r || out_tready);
  assign div_start = (state_r == ST_T4);

  assign e_ext   = {e_r[ELEM_W-1], e_r};
  assign e_mag   = e_r[ELEM_W-1] ? (~e_ext + (ELEM_W+1)'(1)) : e_ext;
  assign sum_mag = sum_r[SUM_W-1] ? (~sum_r + SUM_W'(1)) : sum_r;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQ: begin
        mul_a = MUL_W'(e_mag);
        mul_b = MUL_W'(e_mag);
      end
      ST_T0: begin
        mul_a = MUL_W'(cnt_r);
        mul_b = sq_r[MUL_W-1:0];
      end
      ST_T1: begin
        mul_a = MUL_W'(cnt_r);
        mul_b = MUL_W'(sq_r[SQ_W-1:MUL_W]);
      end
      ST_T2: begin
        mul_a = mag_r;
        mul_b = mag_r;
      end
      ST_T3: begin
        mul_a = MUL_W'(cnt_r);
        mul_b = MUL_W'(cnt_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (quot > cfg.high_thr) begin
      probe_sel = cfg.probe_high;
    end else if (quot < cfg.low_thr) begin
      probe_sel = cfg.probe_low;
    end else begin
      probe_sel = cfg.probe_mid;
    end
    zc_sel = ovf_r ? (cnt_r >= cfg.zc_len) : (cnt_r > cfg.zc_len);
  end

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (room) begin
            sum_nxt   = sum_r + {{(SUM_W-ELEM_W){in_tdata[ELEM_W-1]}}, in_tdata};
            cnt_nxt   = cnt_r + CNT_W'(1);
            state_nxt = ST_SQ;
          end else begin
            ovf_nxt = 1'b1;
            if (in_tlast) begin
              state_nxt = ST_T0;
            end
          end
        end
      end
      ST_SQ: begin
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        sq_nxt    = sq_r + mul_p[SQ_W-1:0];
        state_nxt = last_r ? ST_T0 : ST_IDLE;
      end
      ST_T0: state_nxt = ST_T1;
      ST_T1: state_nxt = ST_T2;
      ST_T2: state_nxt = ST_T3;
      ST_T3: state_nxt = ST_T4;
      ST_T4: state_nxt = ST_FIN;
      ST_FIN: begin
        if (fin_load) begin
          sum_nxt   = '0;
          sq_nxt    = '0;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      sq_r        <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // divider runs while the sequencer parks in the final state
      if (state_r == ST_FIN && !div_stat.done && div_stat.busy) begin
        state_r <= ST_FIN;
      end else begin
        state_r <= state_nxt;
      end
      sum_r <= sum_nxt;
      sq_r  <= sq_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      if (fin_load && !div_stat.busy) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      e_r    <= in_tdata;
      last_r <= in_tlast;
    end
    unique case (state_r)
      ST_T0: mag_r <= sum_mag[MUL_W-1:0];
      ST_T1: acc_r <= mul_p;
      ST_T2: acc_r <= acc_r + {mul_p[PROD_W-MUL_W-1:0], {MUL_W{1'b0}}};
      ST_T3: acc_r <= (acc_r >= mul_p) ? (acc_r - mul_p) : '0;
      default: begin
      end
    endcase
    if (fin_load && !div_stat.busy) begin
      probe_out_r <= probe_sel;
      var_out_r   <= quot;
      zc_out_r    <= zc_sel;
      tl_out_r    <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(48-VAR_W-PROBE_W){1'b0}}, var_out_r, probe_out_r};
  assign out_tuser  = {tl_out_r, zc_out_r};

  `VVPS_ASSERT(a_div_busy_in_fin, div_stat.busy |-> state_r == ST_FIN)
  `VVPS_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(MAX_LEN))
  `VVPS_ASSERT(a_ovf_full, ovf_r |-> cnt_r == CNT_W'(MAX_LEN))
  `VVPS_ASSERT_NEXT(a_clear_after_result, fin_load && !div_stat.busy,
                    cnt_r == '0 && !ovf_r && sum_r == '0 && sq_r == '0)
  `VVPS_ASSERT_NEXT(a_result_loaded, fin_load && !div_stat.busy, out_valid_r)

endmodule
